// ===== rtl/bdrs_pkg.sv =====
`default_nettype none

package bdrs_pkg;

    // field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 42;
    localparam int BS_W  = 11;

    // default number of entries
    localparam int DEPTH_DEF = 1024;

    // block size after reset
    localparam logic [BS_W-1:0] BS_RESET = 11'd32;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [BS_W-1:0]         bsz_t;

    // operation codes
    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

endpackage : bdrs_pkg

`default_nettype wire

// ===== rtl/block_decomposed_range_sum_top.sv =====
`default_nettype none

// Range-sum store over DEPTH signed 32-bit entries with one running 42-bit
// total per block of a programmable number of entries (the block length set
// through cfg_data). Every update inside the memory and every non-empty query
// first runs a one-bit-per-cycle divider to find its block and offset; an
// update at a position at or beyond DEPTH is dropped. An update then reads the
// old entry and block total and writes both back. A query then walks the range
// with one memory read per cycle: each entry outside whole aligned blocks
// costs one read of that entry and each whole block one read of its total;
// the result then waits in the result state while the receiver stalls a
// result still held in the output register. Results wrap modulo 2^42, an empty
// range gives zero. After reset both memories are cleared one entry per cycle,
// and no item is taken until that ends; block length writes are taken at any
// time but must be made before the first update.
module block_decomposed_range_sum_top #(
    parameter int DEPTH = bdrs_pkg::DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration
    input  wire logic          cfg_we,
    input  wire bdrs_pkg::bsz_t cfg_data,
    // item channel
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bdrs_pkg::op_t op,
    input  wire bdrs_pkg::idx_t position,
    input  wire bdrs_pkg::val_t new_value,
    input  wire bdrs_pkg::idx_t range_end,
    // result channel
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bdrs_pkg::sum_t     total
);

    import bdrs_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(IDX_W);
    localparam int WW    = BS_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_WALK,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    bsz_t                  bs_reg, bs_next;
    logic [AW-1:0]         clr_reg, clr_next;
    op_t                   op_reg, op_next;
    idx_t                  pos_reg, pos_next;
    val_t                  val_reg, val_next;
    idx_t                  last_reg, last_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    idx_t                  dq_reg, dq_next;
    bsz_t                  rem_reg, rem_next;
    logic [IDX_W:0]        idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic                  pend_blk_reg, pend_blk_next;
    sum_t                  acc_reg, acc_next;
    sum_t                  total_reg, total_next;
    logic                  out_valid_reg, out_valid_next;

    // memory ports
    logic [AW-1:0]         el_addr, bt_addr;
    logic                  el_we, bt_we;
    val_t                  el_wdata, el_q;
    sum_t                  bt_wdata, bt_q;

    val_t                  el_mem [DEPTH];
    sum_t                  bt_mem [DEPTH];

    // helpers
    logic                  in_xfer;
    bsz_t                  bs_eff;
    idx_t                  last_clamp;
    logic                  pos_oob;
    logic [WW-1:0]         div_shl;
    logic                  div_ge;
    logic                  walk_go;
    logic                  walk_jump;
    bsz_t                  off_inc;
    sum_t                  diff;

    assign req_stall = (state_reg != ST_IDLE);
    assign in_xfer   = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign total     = total_reg;

    assign bs_eff     = (bs_reg == '0) ? BS_W'(1) : bs_reg;
    assign pos_oob    = (32'(position) >= DEPTH);
    assign last_clamp = (32'(range_end) >= DEPTH) ? IDX_W'(DEPTH - 1) : range_end;

    // restoring divider step
    assign div_shl = {rem_reg, dq_reg[IDX_W-1]};
    assign div_ge  = (div_shl >= WW'(bs_eff));

    // walk decisions
    assign walk_go   = (idx_reg <= (IDX_W + 1)'(last_reg));
    assign walk_jump = (rem_reg == '0)
                       && ((WW'(idx_reg) + WW'(bs_eff)) <= (WW'(last_reg) + WW'(1)));
    assign off_inc   = rem_reg + BS_W'(1);

    // update difference against the old entry
    assign diff = SUM_W'(val_reg) - SUM_W'(el_q);

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        bs_next        = bs_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_blk_next  = pend_blk_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;

        el_addr  = AW'(pos_reg);
        bt_addr  = AW'(dq_reg);
        el_we    = 1'b0;
        bt_we    = 1'b0;
        el_wdata = val_reg;
        bt_wdata = bt_q + diff;

        if (cfg_we)
        begin
            bs_next = cfg_data;
        end

        // result transfer frees the output register
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        // accumulate data from last cycle's read
        if (pend_reg)
        begin
            acc_next = acc_reg + (pend_blk_reg ? bt_q : SUM_W'(el_q));
        end

        case (state_reg)
            ST_CLEAR:
            begin
                el_addr  = clr_reg;
                bt_addr  = clr_reg;
                el_we    = 1'b1;
                bt_we    = 1'b1;
                el_wdata = '0;
                bt_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next   = op;
                    pos_next  = position;
                    val_next  = new_value;
                    last_next = last_clamp;
                    idx_next  = (IDX_W + 1)'(position);
                    dq_next   = position;
                    rem_next  = '0;
                    cnt_next  = '0;
                    acc_next  = '0;
                    if (op == OP_UPDATE)
                    begin
                        if (!pos_oob)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else if (position > last_clamp)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next = div_ge ? BS_W'(div_shl - WW'(bs_eff)) : div_shl[BS_W-1:0];
                dq_next  = {dq_reg[IDX_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(IDX_W - 1))
                begin
                    state_next = (op_reg == OP_UPDATE) ? ST_UPD_RD : ST_WALK;
                end
            end

            ST_UPD_RD:
            begin
                // reads of old entry and block total issued here
                state_next = ST_UPD_WR;
            end

            ST_UPD_WR:
            begin
                el_we      = 1'b1;
                bt_we      = 1'b1;
                state_next = ST_IDLE;
            end

            ST_WALK:
            begin
                el_addr = AW'(idx_reg);
                bt_addr = AW'(dq_reg);
                if (walk_go)
                begin
                    pend_next = 1'b1;
                    if (walk_jump)
                    begin
                        pend_blk_next = 1'b1;
                        idx_next      = idx_reg + (IDX_W + 1)'(bs_eff);
                        dq_next       = dq_reg + IDX_W'(1);
                    end
                    else
                    begin
                        pend_blk_next = 1'b0;
                        idx_next      = idx_reg + (IDX_W + 1)'(1);
                        if (off_inc == bs_eff)
                        begin
                            rem_next = '0;
                            dq_next  = dq_reg + IDX_W'(1);
                        end
                        else
                        begin
                            rem_next = off_inc;
                        end
                    end
                end
                else
                begin
                    // last pending read is added this cycle
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    total_next     = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            bs_reg        <= BS_RESET;
            clr_reg       <= '0;
            op_reg        <= OP_UPDATE;
            pos_reg       <= '0;
            val_reg       <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            dq_reg        <= '0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_blk_reg  <= 1'b0;
            acc_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bs_reg        <= bs_next;
            clr_reg       <= clr_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            dq_reg        <= dq_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_blk_reg  <= pend_blk_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (el_we)
        begin
            el_mem[el_addr] <= el_wdata;
        end
        el_q <= el_mem[el_addr];
    end

    // block total memory
    always_ff @(posedge clk)
    begin
        if (bt_we)
        begin
            bt_mem[bt_addr] <= bt_wdata;
        end
        bt_q <= bt_mem[bt_addr];
    end

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < bs_eff))
        else $error("divider remainder not below block size");

    // walk offset stays inside its block
    a_walk_off: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (rem_reg < bs_eff))
        else $error("walk offset outside block");

    // walk reads stay inside the memory
    a_walk_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && walk_go) |-> (32'(idx_reg) < DEPTH))
        else $error("walk read beyond depth");

    // a new item never starts with a read still in flight
    a_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !pend_reg)
        else $error("item taken with read in flight");

    // a query result is only loaded from the result state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside result state");

endmodule : block_decomposed_range_sum_top

`default_nettype wire
